// File: src/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg
// Shared types, constants and arithmetic helpers for the comb/allpass reverb.
// ----------------------------------------------------------------------------
package car_pkg;

  // Default build parameters
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int NUM_COMB_DEF    = 8;
  localparam int NUM_AP_DEF      = 4;
  localparam int COMB_MAX_DEF    = 2048;
  localparam int AP_MAX_DEF      = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_FB     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_DAMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AP_FB       = 3'd6;

  // Register reset values
  localparam logic        RST_ENABLE     = 1'b1;
  localparam logic [15:0] RST_COMB_FB    = 16'd11010;
  localparam logic [15:0] RST_COMB_DAMP  = 16'd13107;
  localparam logic [16:0] RST_WET_MIX    = 17'd19661;
  localparam logic [15:0] RST_INPUT_GAIN = 16'd983;
  localparam logic [15:0] RST_WET_GAIN   = 16'd24576;
  localparam logic [15:0] RST_AP_FB      = 16'd32768;

  // Coefficient limits
  localparam logic [15:0] FB_LIMIT  = 16'd64225;
  localparam logic [16:0] UNITY_Q16 = 17'h10000;

  // Datapath widths: multiplier operands, product, accumulator
  localparam int MA_W   = 36;
  localparam int MB_W   = 18;
  localparam int PROD_W = 54;
  localparam int ACC_W  = 56;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t MAX32 = 56'sh0000_007F_FFFF_FF;
  localparam acc_t MIN32 = -56'sh0000_0080_0000_00;

  typedef struct packed {
    logic        enable;
    logic [15:0] comb_feedback;
    logic [15:0] comb_damping;
    logic [16:0] wet_mix;
    logic [15:0] input_gain;
    logic [15:0] wet_gain;
    logic [15:0] allpass_feedback;
  } car_cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } car_stat_t;

  // Freeverb comb tunings; upper eight are the right-channel set
  function automatic logic [12:0] comb_tune(input logic [3:0] i);
    logic [12:0] t;
    case (i)
      4'd0:    t = 13'd1116;
      4'd1:    t = 13'd1188;
      4'd2:    t = 13'd1277;
      4'd3:    t = 13'd1356;
      4'd4:    t = 13'd1422;
      4'd5:    t = 13'd1491;
      4'd6:    t = 13'd1557;
      4'd7:    t = 13'd1617;
      4'd8:    t = 13'd1139;
      4'd9:    t = 13'd1211;
      4'd10:   t = 13'd1300;
      4'd11:   t = 13'd1379;
      4'd12:   t = 13'd1445;
      4'd13:   t = 13'd1514;
      4'd14:   t = 13'd1580;
      default: t = 13'd1640;
    endcase
    return t;
  endfunction

  function automatic logic [12:0] ap_tune(input logic [2:0] i);
    logic [12:0] t;
    case (i)
      3'd0:    t = 13'd556;
      3'd1:    t = 13'd441;
      3'd2:    t = 13'd341;
      3'd3:    t = 13'd225;
      3'd4:    t = 13'd579;
      3'd5:    t = 13'd464;
      3'd6:    t = 13'd364;
      default: t = 13'd248;
    endcase
    return t;
  endfunction

  // Add half an LSB, then floor
  function automatic acc_t rnd(input acc_t v, input int s);
    acc_t h;
    h = acc_t'(1) <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input acc_t v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/car_in_if.sv
// ----------------------------------------------------------------------------
// car_in_if
// Valid/ready channel carrying one input sample.
// ----------------------------------------------------------------------------
interface car_in_if #(
  parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// File: src/car_out_if.sv
// ----------------------------------------------------------------------------
// car_out_if
// Valid/ready channel carrying one output sample.
// ----------------------------------------------------------------------------
interface car_out_if #(
  parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// File: src/car_ram.sv
// ----------------------------------------------------------------------------
// car_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module car_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/car_fifo.sv
// ----------------------------------------------------------------------------
// car_fifo
// Small show-ahead queue between the front and the back end.
// ----------------------------------------------------------------------------
module car_fifo #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: src/car_front.sv
// ----------------------------------------------------------------------------
// car_front
// Input stage: takes samples, tags them as bypass or reverb, queues them.
// ----------------------------------------------------------------------------
module car_front #(
  parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  car_in_if.sink                 din,
  input  car_pkg::car_cfg_t      cfg,
  input  car_pkg::car_stat_t     stat,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [SAMPLE_BITS:0]   q_data
);
  logic                 hold_valid;
  logic [SAMPLE_BITS:0] hold_data;

  assign q_push    = hold_valid && !q_full;
  assign q_data    = hold_data;
  assign din.ready = !stat.clearing && (!hold_valid || q_push);

  // Holding register; MSB marks a pass-through sample
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      hold_data <= {!cfg.enable, din.sample_in};
    end
  end
endmodule

// File: src/car_engine.sv
// ----------------------------------------------------------------------------
// car_engine
// Back end: sequences combs, allpasses and mix through one shared multiplier.
// ----------------------------------------------------------------------------
module car_engine #(
  parameter int NUM_COMB_STAGES    = car_pkg::NUM_COMB_DEF,
  parameter int NUM_ALLPASS_STAGES = car_pkg::NUM_AP_DEF,
  parameter int COMB_MAX_DELAY     = car_pkg::COMB_MAX_DEF,
  parameter int ALLPASS_MAX_DELAY  = car_pkg::AP_MAX_DEF,
  parameter int SAMPLE_BITS        = car_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  car_pkg::car_cfg_t    cfg,
  input  logic                 q_valid,
  input  logic [SAMPLE_BITS:0] q_data,
  output logic                 q_pop,
  output car_pkg::car_stat_t   stat,
  car_out_if.source            dout
);
  localparam int CD   = NUM_COMB_STAGES * COMB_MAX_DELAY;
  localparam int AD   = NUM_ALLPASS_STAGES * ALLPASS_MAX_DELAY;
  localparam int CAW  = $clog2(CD);
  localparam int AAW  = $clog2(AD);
  localparam int CPW  = $clog2(COMB_MAX_DELAY);
  localparam int APW  = $clog2(ALLPASS_MAX_DELAY);
  localparam int CLR  = (CD > AD) ? CD : AD;
  localparam int CLW  = $clog2(CLR + 1);
  localparam int CIX  = (NUM_COMB_STAGES > 1) ? $clog2(NUM_COMB_STAGES) : 1;
  localparam int AIX  = (NUM_ALLPASS_STAGES > 1) ? $clog2(NUM_ALLPASS_STAGES) : 1;
  localparam int ACC_W  = car_pkg::ACC_W;
  localparam int MA_W   = car_pkg::MA_W;
  localparam int MB_W   = car_pkg::MB_W;
  localparam int PROD_W = car_pkg::PROD_W;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 1;

  // Sequencer states
  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_X    = 5'd2;
  localparam logic [4:0] S_CRD  = 5'd3;
  localparam logic [4:0] S_CM1  = 5'd4;
  localparam logic [4:0] S_CM2  = 5'd5;
  localparam logic [4:0] S_CM3  = 5'd6;
  localparam logic [4:0] S_CM4  = 5'd7;
  localparam logic [4:0] S_CWR  = 5'd8;
  localparam logic [4:0] S_SUM  = 5'd9;
  localparam logic [4:0] S_ARD  = 5'd10;
  localparam logic [4:0] S_AM1  = 5'd11;
  localparam logic [4:0] S_AWR  = 5'd12;
  localparam logic [4:0] S_W1   = 5'd13;
  localparam logic [4:0] S_W2   = 5'd14;
  localparam logic [4:0] S_W3   = 5'd15;
  localparam logic [4:0] S_W4   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  // Per-stage state
  logic [CPW-1:0]           cpos [NUM_COMB_STAGES];
  logic [APW-1:0]           apos [NUM_ALLPASS_STAGES];
  logic signed [31:0]       damp [NUM_COMB_STAGES];

  logic [CIX-1:0]           cidx;
  logic [AIX-1:0]           aidx;
  logic [CAW:0]             cbase;
  logic [AAW:0]             abase;
  logic [CLW-1:0]           clr_cnt;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] dry;
  logic signed [31:0]            x;
  logic signed [31:0]            y;
  logic signed [31:0]            b;
  logic signed [31:0]            sig;
  logic signed [MA_W-1:0]        wet;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       sum;
  logic signed [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0]        res;
  logic                          out_valid;
  logic [SAMPLE_BITS-1:0]        out_data;

  // Multiplier operands
  logic                          mul_en;
  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;

  // Coefficients
  logic [15:0]              fb;
  logic [16:0]              mix;
  logic signed [MB_W-1:0]   one_m_d;
  logic signed [MB_W-1:0]   one_m_mix;

  // RAM ports
  logic                     c_we;
  logic [CAW-1:0]           c_waddr;
  logic [CAW-1:0]           c_raddr;
  logic [31:0]              c_wdata;
  logic [31:0]              c_rdata;
  logic                     a_we;
  logic [AAW-1:0]           a_waddr;
  logic [AAW-1:0]           a_raddr;
  logic [31:0]              a_wdata;
  logic [31:0]              a_rdata;

  // Stage lengths and next positions
  logic [12:0]              ctune;
  logic [12:0]              atune;
  logic [CPW:0]             clen;
  logic [APW:0]             alen;
  logic [CPW:0]             cpos_inc;
  logic [APW:0]             apos_inc;
  logic [CPW-1:0]           cpos_next;
  logic [APW-1:0]           apos_next;

  logic signed [ACC_W-1:0]  acc_prod;
  logic signed [ACC_W-1:0]  rnd_prod;
  logic signed [ACC_W-1:0]  mix_rnd;
  logic                     out_load;

  assign fb        = (cfg.comb_feedback > car_pkg::FB_LIMIT) ? car_pkg::FB_LIMIT
                                                             : cfg.comb_feedback;
  assign mix       = (cfg.wet_mix > car_pkg::UNITY_Q16) ? car_pkg::UNITY_Q16 : cfg.wet_mix;
  assign one_m_d   = MB_W'({1'b0, car_pkg::UNITY_Q16} - {2'b00, cfg.comb_damping});
  assign one_m_mix = MB_W'({1'b0, car_pkg::UNITY_Q16} - {1'b0, mix});

  assign ctune    = car_pkg::comb_tune(4'(cidx));
  assign atune    = car_pkg::ap_tune(3'(aidx));
  assign clen     = (ctune > COMB_MAX_DELAY) ? (CPW+1)'(COMB_MAX_DELAY) : (CPW+1)'(ctune);
  assign alen     = (atune > ALLPASS_MAX_DELAY) ? (APW+1)'(ALLPASS_MAX_DELAY)
                                                : (APW+1)'(atune);
  assign cpos_inc  = {1'b0, cpos[cidx]} + 1'b1;
  assign apos_inc  = {1'b0, apos[aidx]} + 1'b1;
  assign cpos_next = (cpos_inc >= clen) ? '0 : cpos_inc[CPW-1:0];
  assign apos_next = (apos_inc >= alen) ? '0 : apos_inc[APW-1:0];

  assign acc_prod = acc + ACC_W'(prod);
  assign rnd_prod = car_pkg::rnd(ACC_W'(prod), 16);
  assign mix_rnd  = car_pkg::rnd(acc_prod, 16);

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign out_load   = (state == S_DONE) && (!out_valid || dout.ready);
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;
  assign stat.clearing   = (state == S_CLR);
  assign stat.busy       = (state != S_IDLE) && (state != S_CLR);

  // Delay memories
  car_ram #(.WIDTH(32), .DEPTH(CD)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  car_ram #(.WIDTH(32), .DEPTH(AD)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // RAM address and write selection
  always_comb begin
    c_raddr = CAW'(cbase + (CAW+1)'(cpos[cidx]));
    a_raddr = AAW'(abase + (AAW+1)'(apos[aidx]));
    c_waddr = c_raddr;
    a_waddr = a_raddr;
    c_we    = 1'b0;
    a_we    = 1'b0;
    c_wdata = car_pkg::sat32(ACC_W'(x) + rnd_prod);
    a_wdata = car_pkg::sat32(ACC_W'(sig) + rnd_prod);
    if (state == S_CLR) begin
      c_waddr = CAW'(clr_cnt);
      a_waddr = AAW'(clr_cnt);
      c_wdata = '0;
      a_wdata = '0;
      c_we    = (clr_cnt < CLW'(CD));
      a_we    = (clr_cnt < CLW'(AD));
    end else if (state == S_CWR) begin
      c_we = 1'b1;
    end else if (state == S_AWR) begin
      a_we = 1'b1;
    end
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_X: begin
        mul_a = MA_W'(dry);
        mul_b = MB_W'({2'b00, cfg.input_gain});
      end
      S_CM1: begin
        mul_a = MA_W'($signed(c_rdata));
        mul_b = one_m_d;
      end
      S_CM2: begin
        mul_a = MA_W'(damp[cidx]);
        mul_b = MB_W'({2'b00, cfg.comb_damping});
      end
      S_CM4: begin
        mul_a = MA_W'(damp[cidx]);
        mul_b = MB_W'({2'b00, fb});
      end
      S_AM1: begin
        mul_a = MA_W'($signed(a_rdata));
        mul_b = MB_W'({2'b00, cfg.allpass_feedback});
      end
      S_W1: begin
        mul_a = MA_W'(sig);
        mul_b = MB_W'({2'b00, cfg.wet_gain});
      end
      S_W2: begin
        mul_a = MA_W'(dry);
        mul_b = one_m_mix;
      end
      S_W3: begin
        mul_a = wet;
        mul_b = MB_W'({1'b0, mix});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  state_next = (clr_cnt == CLW'(CLR - 1)) ? S_IDLE : S_CLR;
      S_IDLE: begin
        if (q_valid) begin
          state_next = q_data[SAMPLE_BITS] ? S_DONE : S_X;
        end
      end
      S_X:    state_next = S_CRD;
      S_CRD:  state_next = S_CM1;
      S_CM1:  state_next = S_CM2;
      S_CM2:  state_next = S_CM3;
      S_CM3:  state_next = S_CM4;
      S_CM4:  state_next = S_CWR;
      S_CWR:  state_next = (cidx == CIX'(NUM_COMB_STAGES - 1)) ? S_SUM : S_CRD;
      S_SUM:  state_next = S_ARD;
      S_ARD:  state_next = S_AM1;
      S_AM1:  state_next = S_AWR;
      S_AWR:  state_next = (aidx == AIX'(NUM_ALLPASS_STAGES - 1)) ? S_W1 : S_ARD;
      S_W1:   state_next = S_W2;
      S_W2:   state_next = S_W3;
      S_W3:   state_next = S_W4;
      S_W4:   state_next = S_DONE;
      S_DONE: state_next = out_load ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      cidx      <= '0;
      aidx      <= '0;
      cbase     <= '0;
      abase     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_COMB_STAGES; i++) begin
        cpos[i] <= '0;
        damp[i] <= '0;
      end
      for (int i = 0; i < NUM_ALLPASS_STAGES; i++) begin
        apos[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_X: begin
          cidx  <= '0;
          cbase <= '0;
        end
        S_CM3: begin
          damp[cidx] <= car_pkg::sat32(car_pkg::rnd(acc_prod, 16));
        end
        S_CWR: begin
          cpos[cidx] <= cpos_next;
          cidx       <= cidx + 1'b1;
          cbase      <= cbase + (CAW+1)'(COMB_MAX_DELAY);
        end
        S_SUM: begin
          aidx  <= '0;
          abase <= '0;
        end
        S_AWR: begin
          apos[aidx] <= apos_next;
          aidx       <= aidx + 1'b1;
          abase      <= abase + (AAW+1)'(ALLPASS_MAX_DELAY);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dry <= $signed(q_data[SAMPLE_BITS-1:0]);
      res <= q_data[SAMPLE_BITS-1:0];
      sum <= '0;
    end
    if (state == S_CRD && cidx == '0) begin
      x <= car_pkg::sat32(rnd_prod);
    end
    if (state == S_CM1) begin
      y <= $signed(c_rdata);
    end
    if (state == S_CM2) begin
      acc <= ACC_W'(prod);
    end
    if (state == S_CWR) begin
      sum <= sum + ACC_W'(y);
    end
    if (state == S_SUM) begin
      sig <= car_pkg::sat32(sum);
    end
    if (state == S_AM1) begin
      b <= $signed(a_rdata);
    end
    if (state == S_AWR) begin
      sig <= car_pkg::sat32(ACC_W'(b) - ACC_W'(sig));
    end
    if (state == S_W2) begin
      wet <= MA_W'(car_pkg::rnd(ACC_W'(prod), 13));
    end
    if (state == S_W3) begin
      acc <= ACC_W'(prod);
    end
    if (state == S_W4) begin
      if (mix_rnd > SMAX) begin
        res <= SMAX[SAMPLE_BITS-1:0];
      end else if (mix_rnd < SMIN) begin
        res <= SMIN[SAMPLE_BITS-1:0];
      end else begin
        res <= mix_rnd[SAMPLE_BITS-1:0];
      end
    end
    if (out_load) begin
      out_data <= res;
    end
  end
endmodule

// File: src/comb_allpass_reverb.sv
// ----------------------------------------------------------------------------
// comb_allpass_reverb
// Freeverb-style reverb: parallel damped combs, series allpasses, wet/dry mix.
// ----------------------------------------------------------------------------
// After reset the block walks max(NUM_COMB_STAGES*COMB_MAX_DELAY,
// NUM_ALLPASS_STAGES*ALLPASS_MAX_DELAY) addresses (16384 by default),
// zeroing its delay memories; din.ready stays low during that pass while
// configuration writes are still taken. A processed sample is sequenced
// through the single shared multiplier, which visits every comb, allpass
// and mix term in turn; a pass-through sample (enable = 0) skips the
// filter states. A two-entry queue sits between the input stage and the
// filter engine, and a finished sample waits in its own output register,
// so input is taken while output stalls. Configuration writes belong
// between samples, with the block idle.
// ----------------------------------------------------------------------------
module comb_allpass_reverb #(
  parameter int NUM_COMB_STAGES    = car_pkg::NUM_COMB_DEF,
  parameter int NUM_ALLPASS_STAGES = car_pkg::NUM_AP_DEF,
  parameter int COMB_MAX_DELAY     = car_pkg::COMB_MAX_DEF,
  parameter int ALLPASS_MAX_DELAY  = car_pkg::AP_MAX_DEF,
  parameter int SAMPLE_BITS        = car_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  car_in_if.sink                            din,
  car_out_if.source                         dout,
  input  logic                              cfg_we,
  input  logic [car_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [car_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int QW = SAMPLE_BITS + 1;

  car_pkg::car_cfg_t  cfg;
  car_pkg::car_stat_t stat;
  logic               q_push;
  logic [QW-1:0]      q_in;
  logic               q_pop;
  logic [QW-1:0]      q_out;
  logic               q_full;
  logic               q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= car_pkg::RST_ENABLE;
      cfg.comb_feedback    <= car_pkg::RST_COMB_FB;
      cfg.comb_damping     <= car_pkg::RST_COMB_DAMP;
      cfg.wet_mix          <= car_pkg::RST_WET_MIX;
      cfg.input_gain       <= car_pkg::RST_INPUT_GAIN;
      cfg.wet_gain         <= car_pkg::RST_WET_GAIN;
      cfg.allpass_feedback <= car_pkg::RST_AP_FB;
    end else if (cfg_we) begin
      case (cfg_index)
        car_pkg::REG_ENABLE:     cfg.enable           <= cfg_data[0];
        car_pkg::REG_COMB_FB:    cfg.comb_feedback    <= cfg_data[15:0];
        car_pkg::REG_COMB_DAMP:  cfg.comb_damping     <= cfg_data[15:0];
        car_pkg::REG_WET_MIX:    cfg.wet_mix          <= cfg_data;
        car_pkg::REG_INPUT_GAIN: cfg.input_gain       <= cfg_data[15:0];
        car_pkg::REG_WET_GAIN:   cfg.wet_gain         <= cfg_data[15:0];
        car_pkg::REG_AP_FB:      cfg.allpass_feedback <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage
  car_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .cfg    (cfg),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Queue between front and engine
  car_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // Filter engine
  car_engine #(
    .NUM_COMB_STAGES    (NUM_COMB_STAGES),
    .NUM_ALLPASS_STAGES (NUM_ALLPASS_STAGES),
    .COMB_MAX_DELAY     (COMB_MAX_DELAY),
    .ALLPASS_MAX_DELAY  (ALLPASS_MAX_DELAY),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .stat    (stat),
    .dout    (dout)
  );

  // No input taken while the delay memories are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !din.ready)
    else $error("input accepted during memory clear");

  // The clearing pass runs only once, right after reset
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !stat.clearing |=> !stat.clearing)
    else $error("memory clear restarted");

  // The engine pops only a non-empty queue and only while idle
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && !stat.clearing && !stat.busy)
    else $error("engine popped an empty queue");
endmodule
